// ===== design/api_frame_receiver_assert.svh =====
// Assertion macros used by the api_frame_receiver top module.
`ifndef API_FRAME_RECEIVER_ASSERT_SVH
`define API_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define AFR_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define AFR_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/afr_pkg.sv =====
// Types and constants shared by the API frame receiver modules.
`default_nettype none

package afr_pkg;

   localparam int FRAME_BYTES = 13;
   localparam int POS_W       = 4;

   localparam logic [7:0]       DELIM       = 8'h7E;
   localparam logic [7:0]       LEN_OFFSET  = 8'd4;
   localparam logic [7:0]       CSUM_BASE   = 8'hFF;
   localparam logic [POS_W-1:0] FRAME_LEN   = POS_W'(FRAME_BYTES);
   localparam logic [POS_W-1:0] SHORT_LEN   = 4'd7;
   localparam logic [POS_W-1:0] POS_LEN     = 4'd2;
   localparam int               POS_API     = 3;
   localparam int               POS_MSG     = 8;
   localparam int               POS_PAYLOAD = 9;
   localparam int               POS_CSUM    = FRAME_BYTES - 1;

   localparam logic [7:0] RST_API_ID   = 8'h81;
   localparam logic [7:0] RST_PAIR_ACK = 8'h04;
   localparam logic [7:0] RST_STATUS   = 8'h02;

   // Register indexes on the configuration channel.
   localparam logic [1:0] CSR_API_ID   = 2'd0;
   localparam logic [1:0] CSR_PAIR_ACK = 2'd1;
   localparam logic [1:0] CSR_STATUS   = 2'd2;

   typedef enum logic [1:0] {
      KIND_PAIR_ACK = 2'd0,
      KIND_STATUS   = 2'd1,
      KIND_OTHER    = 2'd2
   } frame_kind_type;

   typedef struct packed {
      logic [7:0] expected_api_id;
      logic [7:0] pair_ack_msg_id;
      logic [7:0] status_msg_id;
   } cfg_type;

   typedef struct packed {
      logic [7:0]     payload_value;
      logic           checksum_ok;
      frame_kind_type frame_kind;
   } rsp_type;

endpackage

`default_nettype wire

// ===== design/afr_csr_regs.sv =====
// Configuration registers of the API frame receiver.
`default_nettype none

module afr_csr_regs (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           csr_valid,
   output logic                csr_ready,
   input  wire logic [1:0]     csr_index,
   input  wire logic [7:0]     csr_data,
   output afr_pkg::cfg_type    cfg
);
   import afr_pkg::*;

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_api_id <= RST_API_ID;
         cfg_ff.pair_ack_msg_id <= RST_PAIR_ACK;
         cfg_ff.status_msg_id   <= RST_STATUS;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_API_ID:   cfg_ff.expected_api_id <= csr_data;
            CSR_PAIR_ACK: cfg_ff.pair_ack_msg_id <= csr_data;
            CSR_STATUS:   cfg_ff.status_msg_id   <= csr_data;
            default:      ; // unmapped index: drop the write
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== design/afr_deframer.sv =====
// Frame buffer, position tracking, checksum and classification of one byte.
`default_nettype none

module afr_deframer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        item_valid,
   input  wire logic [7:0]  rx_byte,
   input  wire afr_pkg::cfg_type cfg,
   output logic             res_valid,
   output afr_pkg::rsp_type res
);
   import afr_pkg::*;

   logic [7:0]       store_ff [FRAME_BYTES];
   logic [7:0]       store_in [FRAME_BYTES];
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] len_ff, len_in;
   logic             in_frame_ff, in_frame_in;
   logic             frame_end;
   logic [7:0]       len_byte;
   logic [7:0]       sum;

   assign len_byte = rx_byte + LEN_OFFSET;

   always_comb begin
      store_in    = store_ff;
      pos_in      = pos_ff;
      len_in      = len_ff;
      in_frame_in = in_frame_ff;
      frame_end   = 1'b0;
      if (rx_byte == DELIM) begin
         store_in[0] = rx_byte;
         in_frame_in = 1'b1;
         pos_in      = POS_W'(1);
      end else if (in_frame_ff) begin
         if (pos_ff >= FRAME_LEN) begin
            // out of range: close the frame quietly
            in_frame_in = 1'b0;
            pos_in      = '0;
         end else begin
            for (int i = 0; i < FRAME_BYTES; i++) begin
               if (pos_ff == POS_W'(i)) store_in[i] = rx_byte;
            end
            if (pos_ff == POS_LEN) begin
               len_in = (len_byte == 8'(FRAME_BYTES)) ? FRAME_LEN : SHORT_LEN;
               pos_in = pos_ff + POS_W'(1);
            end else if (({1'b0, pos_ff} + 5'd1) < {1'b0, len_ff}) begin
               pos_in = pos_ff + POS_W'(1);
            end else begin
               in_frame_in = 1'b0;
               pos_in      = '0;
               frame_end   = 1'b1;
            end
         end
      end
   end

   // Checksum over the header-to-payload span, current byte included.
   always_comb begin
      sum = '0;
      for (int i = POS_API; i < POS_CSUM; i++) begin
         sum = sum + store_in[i];
      end
   end

   always_comb begin
      res.payload_value = store_in[POS_PAYLOAD];
      res.checksum_ok   = ((CSUM_BASE - sum) == store_in[POS_CSUM]);
      priority if (store_in[POS_MSG] == cfg.pair_ack_msg_id) begin
         res.frame_kind = KIND_PAIR_ACK;
      end else if (store_in[POS_MSG] == cfg.status_msg_id) begin
         res.frame_kind = KIND_STATUS;
      end else begin
         res.frame_kind = KIND_OTHER;
      end
      res_valid = item_valid && frame_end && (store_in[POS_API] == cfg.expected_api_id);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FRAME_BYTES; i++) begin
            store_ff[i] <= '0;
         end
         pos_ff      <= '0;
         len_ff      <= SHORT_LEN;
         in_frame_ff <= 1'b0;
      end else if (item_valid) begin
         store_ff    <= store_in;
         pos_ff      <= pos_in;
         len_ff      <= len_in;
         in_frame_ff <= in_frame_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/afr_rsp_reg.sv =====
// Result register in front of the result channel.
`default_nettype none

module afr_rsp_reg (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        load,
   input  wire afr_pkg::rsp_type load_data,
   output logic             slot_free,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output afr_pkg::rsp_type rsp_data
);
   import afr_pkg::*;

   logic    valid_ff;
   rsp_type data_ff;

   assign slot_free = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

`default_nettype wire

// ===== design/api_frame_receiver.sv =====
// API frame receiver: one byte per transaction, at most one result per frame.
// A result passes from the input register through the result register to rsp.
// Throughput: one byte per cycle; the input register stalls only while the
// result register holds an untaken result.
// Reset (synchronous, active high) clears the frame buffer and position, and
// loads the register defaults (API id 0x81, pairing ack 0x04, status 0x02).
`default_nettype none
`include "api_frame_receiver_assert.svh"

module api_frame_receiver (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] rx_byte
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] payload_value
   output logic [2:0]      rsp_tuser,   // [1:0] frame_kind, [2] checksum_ok
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_data
);
   import afr_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       advance;
   logic       slot_free;
   logic       res_valid;
   cfg_type    cfg;
   rsp_type    res;
   rsp_type    rsp_out;

   // Process the held byte only when a result would have somewhere to go.
   assign advance    = in_valid_ff && slot_free;
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   afr_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   afr_deframer u_deframer (
      .clock      (clock),
      .reset      (reset),
      .item_valid (advance),
      .rx_byte    (in_byte_ff),
      .cfg        (cfg),
      .res_valid  (res_valid),
      .res        (res)
   );

   afr_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (res_valid),
      .load_data (res),
      .slot_free (slot_free),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_out)
   );

   assign rsp_tdata = rsp_out.payload_value;
   assign rsp_tuser = {rsp_out.checksum_ok, rsp_out.frame_kind};

   `AFR_ASSERT_IMPL(a_empty_accepts, !in_valid_ff, req_tready, "input register empty but not ready")
   `AFR_ASSERT_IMPL(a_result_needs_advance, res_valid, advance, "result raised without a processed byte")
   `AFR_ASSERT_NEXT(a_result_lands, res_valid, rsp_tvalid, "result lost before the result register")
   `AFR_ASSERT_NEXT(a_stalled_byte_held, in_valid_ff && !advance,
      in_valid_ff && $stable(in_byte_ff), "stalled input byte changed")

endmodule

`default_nettype wire

// ===== test/api_frame_receiver_checker.sv =====
// Checker for the API frame receiver: tracks frames byte by byte and compares reported results.
`timescale 1ns / 1ps

module api_frame_receiver_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] rx_byte
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,   // [7:0] payload_value
   input  logic [2:0] rsp_tuser,   // [1:0] frame_kind, [2] checksum_ok
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data,
   output int         fail_count,
   output int         pending_results
);
   import afr_pkg::*;

   logic [7:0]       frame_bytes [FRAME_BYTES];
   logic [POS_W-1:0] write_pos;
   logic             receiving;
   logic [POS_W-1:0] frame_len;
   cfg_type          regs;
   rsp_type          awaited_frames [$];

   task automatic report_mismatch(input string msg);
      fail_count++;
      $display("%0t ns: %s", $time, msg);
   endtask

   // Advance the frame tracker by one received byte; queue a result at a reported frame end.
   task automatic absorb_rx_byte(input logic [7:0] b);
      logic [7:0] sum;
      rsp_type    r;
      int         i;
      if (b == DELIM) begin
         frame_bytes[0] = b;
         receiving      = 1'b1;
         write_pos      = 1;
         return;
      end
      if (!receiving) return;
      if (int'(write_pos) >= FRAME_BYTES) begin
         receiving = 1'b0;
         write_pos = '0;
         return;
      end
      frame_bytes[write_pos] = b;
      if (write_pos == POS_LEN) begin
         frame_len = (8'(b + LEN_OFFSET) == 8'(FRAME_BYTES)) ? FRAME_LEN : SHORT_LEN;
         write_pos++;
         return;
      end
      if (int'(write_pos) + 1 < int'(frame_len)) begin
         write_pos++;
         return;
      end

      // closing byte: the sum always spans positions POS_API to POS_CSUM-1, stale bytes included
      receiving = 1'b0;
      write_pos = '0;
      sum = '0;
      for (i = POS_API; i < POS_CSUM; i++) sum = sum + frame_bytes[i];
      if (frame_bytes[POS_API] != regs.expected_api_id) return;

      if (frame_bytes[POS_MSG] == regs.pair_ack_msg_id) r.frame_kind = KIND_PAIR_ACK;
      else if (frame_bytes[POS_MSG] == regs.status_msg_id) r.frame_kind = KIND_STATUS;
      else r.frame_kind = KIND_OTHER;
      r.checksum_ok   = (8'(CSUM_BASE - sum) == frame_bytes[POS_CSUM]);
      r.payload_value = frame_bytes[POS_PAYLOAD];
      awaited_frames.push_back(r);
   endtask

   task automatic compare_result();
      rsp_type want;
      if (awaited_frames.size() == 0) begin
         report_mismatch($sformatf("result with none expected: tdata %0h tuser %0h",
                                   rsp_tdata, rsp_tuser));
         return;
      end
      want = awaited_frames.pop_front();
      if (rsp_tuser[1:0] !== want.frame_kind)
         report_mismatch($sformatf("frame_kind expected %0d got %0d",
                                   want.frame_kind, rsp_tuser[1:0]));
      if (rsp_tuser[2] !== want.checksum_ok)
         report_mismatch($sformatf("checksum_ok expected %0b got %0b",
                                   want.checksum_ok, rsp_tuser[2]));
      if (rsp_tdata !== want.payload_value)
         report_mismatch($sformatf("payload_value expected %0h got %0h",
                                   want.payload_value, rsp_tdata));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (frame_bytes[k]) frame_bytes[k] = '0;
         write_pos  = '0;
         receiving  = 1'b0;
         frame_len  = SHORT_LEN;
         regs       = '{RST_API_ID, RST_PAIR_ACK, RST_STATUS};
         fail_count = 0;
         awaited_frames.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) compare_result();
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_API_ID:   regs.expected_api_id = csr_data;
               CSR_PAIR_ACK: regs.pair_ack_msg_id = csr_data;
               CSR_STATUS:   regs.status_msg_id   = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) absorb_rx_byte(req_tdata);
      end
      pending_results = awaited_frames.size();
   end

endmodule

// ===== test/api_frame_receiver_tb.sv =====
// Testbench top for the API frame receiver: clock, reset, byte and register stimulus, verdict.
`timescale 1ns / 1ps

module api_frame_receiver_tb;
   import afr_pkg::*;

   localparam int IDLE_PCT        = 28;
   localparam int PHASE_BYTES     = 220;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 8;
   localparam int STALL_LIMIT     = 5000;
   localparam logic [7:0] FULL_LEN_BYTE = 8'(FRAME_BYTES) - LEN_OFFSET;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic       csr_valid;
   logic       csr_ready;
   logic [1:0] csr_index;
   logic [7:0] csr_data;

   int      fail_count;
   int      pending_results;
   int      bytes_sent;
   int      quiet_cycles;
   logic    idling_on;
   logic    rsp_hold_req;
   cfg_type target_regs;

   api_frame_receiver dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   api_frame_receiver_checker rsp_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver side: random back-pressure, or a long hold-off when asked.
   initial begin
      logic hold_seen;
      hold_seen  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req !== hold_seen) begin
            hold_seen = rsp_hold_req;
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= !idling_on || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [7:0] data_byte();
      logic [7:0] b;
      b = 8'($urandom_range(255));
      return (b == DELIM) ? ~b : b;
   endfunction

   task automatic send_byte(input logic [7:0] b);
      if (idling_on) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   // Send a frame, or its first n_bytes when n_bytes is non-zero.
   task automatic send_frame(input logic [7:0] api_id, input logic [7:0] msg_id,
                             input bit full_len, input bit good_csum, input int n_bytes);
      logic [7:0] f [FRAME_BYTES];
      logic [7:0] sum;
      int         count;
      f[0] = DELIM;
      foreach (f[k]) if (k > 0) f[k] = data_byte();
      if (full_len) f[POS_LEN] = FULL_LEN_BYTE;
      else if (f[POS_LEN] == FULL_LEN_BYTE) f[POS_LEN] = ~FULL_LEN_BYTE;
      f[POS_API] = api_id;
      f[POS_MSG] = msg_id;
      sum = '0;
      for (int k = POS_API; k < POS_CSUM; k++) sum = sum + f[k];
      if (good_csum) f[POS_CSUM] = CSUM_BASE - sum;
      count = (n_bytes > 0) ? n_bytes : (full_len ? FRAME_BYTES : int'(SHORT_LEN));
      for (int k = 0; k < count; k++) send_byte(f[k]);
   endtask

   function automatic logic [7:0] pick_msg_id();
      case ($urandom_range(2))
         0:       return target_regs.pair_ack_msg_id;
         1:       return target_regs.status_msg_id;
         default: return data_byte();
      endcase
   endfunction

   function automatic logic [7:0] pick_api_id();
      return ($urandom_range(99) < 85) ? target_regs.expected_api_id : data_byte();
   endfunction

   task automatic run_random(input int n_bytes);
      int start;
      int sel;
      start = bytes_sent;
      while (bytes_sent - start < n_bytes) begin
         sel = $urandom_range(99);
         if (sel < 65)
            send_frame(pick_api_id(), pick_msg_id(), 1'b1, $urandom_range(99) < 80, 0);
         else if (sel < 78)
            send_frame(pick_api_id(), pick_msg_id(), 1'b0, 1'b1, 0);
         else if (sel < 90)
            send_frame(pick_api_id(), pick_msg_id(), 1'b1, 1'b1, $urandom_range(2, 12));
         else
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
      end
   endtask

   // Hold the sender until every reported frame is back and the pipeline is empty.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      wait (pending_results == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic load_regs(input cfg_type c);
      csr_write(CSR_API_ID, c.expected_api_id);
      csr_write(CSR_PAIR_ACK, c.pair_ack_msg_id);
      csr_write(CSR_STATUS, c.status_msg_id);
      csr_valid <= 1'b0;
      target_regs = c;
   endtask

   initial begin
      logic [7:0] shared_id;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_valid    = 1'b0;
      csr_index    = CSR_API_ID;
      csr_data     = '0;
      idling_on    = 1'b1;
      rsp_hold_req = 1'b0;
      bytes_sent   = 0;
      target_regs  = '{RST_API_ID, RST_PAIR_ACK, RST_STATUS};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Idle bytes before any delimiter, a frame cut short by a new delimiter,
      // a full pairing acknowledge, then a short frame reading stale bytes.
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(RST_API_ID, RST_STATUS, 1'b1, 1'b1, 4);
      send_frame(RST_API_ID, RST_PAIR_ACK, 1'b1, 1'b1, 0);
      send_frame(RST_API_ID, RST_STATUS, 1'b0, 1'b1, 0);
      run_random(PHASE_BYTES);
      drain_results();

      load_regs('{8'h00, 8'hFF, 8'h00});
      run_random(PHASE_BYTES);
      drain_results();

      load_regs('{8'hFF, 8'h00, 8'hFF});
      run_random(PHASE_BYTES);
      drain_results();

      // Both message-id registers equal: pairing acknowledge must win.
      shared_id = data_byte();
      load_regs('{data_byte(), shared_id, shared_id});
      run_random(PHASE_BYTES);
      drain_results();

      // No idling, and the receiver stalls long enough to back the block up.
      load_regs('{data_byte(), data_byte(), data_byte()});
      idling_on    = 1'b0;
      rsp_hold_req = 1'b1;
      run_random(PHASE_BYTES);
      drain_results();
      idling_on = 1'b1;

      load_regs('{RST_API_ID, RST_PAIR_ACK, RST_STATUS});
      run_random(PHASE_BYTES);
      drain_results();

      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/afr_pkg.sv
design/afr_csr_regs.sv
design/afr_deframer.sv
design/afr_rsp_reg.sv
design/api_frame_receiver.sv
test/api_frame_receiver_checker.sv
test/api_frame_receiver_tb.sv
